FILE: design/gn2d_pkg.sv
// Package for the gradient noise block: opcodes and the pipeline control word.
// Used by gradient_noise_2d_1d; no dependencies.
package gn2d_pkg;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_2D   = 2'd1,
    OP_1D   = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    logic vld;
    op_t  op;
  } ctl_t;

  localparam int OUT_W = 21;
  localparam int OUT_FRAC = 16;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 21'sd1048575;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -21'sd1048576;

endpackage

FILE: design/gn2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gn2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/gradient_noise_2d_1d.sv
// Top level of the gradient noise block (2D improved gradient noise, 1D variant).
// Depends on gn2d_pkg and gn2d_ram (ten table copies, one per lookup).
//
//  channel  signals                                              dir
//  input    in_valid in_ready opcode coord_x coord_y table_*      in
//  output   out_valid out_ready noise_value                      out
//
// One word per cycle unless the output register stalls; a noise word passes the three
// chained table lookups and the fade/blend multipliers before the output register.
// Each table copy is written when a load word passes that copy's read stage,
// so reads and writes keep word order. TABLE_SIZE must be a power of two.
// The whole pipeline stalls only when the output register is full and not taken.
// Reset clears the control words and out_valid only; the table is undefined until loaded.
module gradient_noise_2d_1d #(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic signed [31:0]            coord_x,
  input  logic signed [31:0]            coord_y,
  input  logic [7:0]                    table_index,
  input  logic [7:0]                    table_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [gn2d_pkg::OUT_W-1:0] noise_value
);

  localparam int AW  = $clog2(TABLE_SIZE);
  localparam int F   = FRAC_BITS;
  localparam int ONE = 1 << F;
  localparam int RW  = F + 8;
  localparam int SH_R = (F >= gn2d_pkg::OUT_FRAC) ? F - gn2d_pkg::OUT_FRAC : 0;
  localparam int SH_L = (F < gn2d_pkg::OUT_FRAC) ? gn2d_pkg::OUT_FRAC - F : 0;
  localparam int XW  = RW + 16;

  localparam logic signed [F+5:0] K15 = (F+6)'(15 * ONE);
  localparam logic [F+3:0]        K10 = (F+4)'(10 * ONE);
  localparam logic signed [RW-1:0] KONE = RW'(ONE);

  gn2d_pkg::ctl_t ctl [1:6];
  logic en, in_fire;

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign in_fire = in_valid && in_ready;

  // stage 0: split, first lookup
  logic signed [31:0] flx, fly;
  logic [AW-1:0] xi0, yi0;
  logic [AW-1:0] widx0;
  assign flx = coord_x >>> F;
  assign fly = coord_y >>> F;
  assign xi0 = flx[AW-1:0];
  assign yi0 = (gn2d_pkg::op_t'(opcode) == gn2d_pkg::OP_2D) ? fly[AW-1:0] : '0;
  assign widx0 = AW'(table_index);

  logic [F-1:0] t1 [2], t2 [2], t3r [2];
  logic [AW-1:0] yi1;
  logic [AW-1:0] widx1, widx2;
  logic [7:0] wval1, wval2;
  logic we1, we2, we3;
  logic [7:0] d1 [2];
  logic [7:0] d2 [4];
  logic [7:0] d3 [4];
  logic [7:0] h1d [2];

  assign we1 = in_fire && gn2d_pkg::op_t'(opcode) == gn2d_pkg::OP_LOAD;
  assign we2 = en && ctl[1].vld && ctl[1].op == gn2d_pkg::OP_LOAD;
  assign we3 = en && ctl[2].vld && ctl[2].op == gn2d_pkg::OP_LOAD;

  gn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_l1a (
    .clk(clk), .we(we1), .waddr(widx0), .wdata(table_value),
    .re(en), .raddr(xi0), .rdata(d1[0]));
  gn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_l1b (
    .clk(clk), .we(we1), .waddr(widx0), .wdata(table_value),
    .re(en), .raddr(xi0 + AW'(1)), .rdata(d1[1]));

  // stage 1: second lookup
  logic [AW-1:0] a1, b1;
  logic [AW-1:0] ad2 [4];
  assign a1 = AW'(d1[0]) + yi1;
  assign b1 = AW'(d1[1]) + yi1;
  assign ad2[0] = a1;
  assign ad2[1] = b1;
  assign ad2[2] = a1 + AW'(1);
  assign ad2[3] = b1 + AW'(1);

  // stage 2: third lookup
  logic [AW-1:0] ad3 [4];

  genvar gi;
  generate
    for (gi = 0; gi < 4; gi++) begin : g_l23
      gn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_l2 (
        .clk(clk), .we(we2), .waddr(widx1), .wdata(wval1),
        .re(en), .raddr(ad2[gi]), .rdata(d2[gi]));
      assign ad3[gi] = AW'(d2[gi]);
      gn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_l3 (
        .clk(clk), .we(we3), .waddr(widx2), .wdata(wval2),
        .re(en), .raddr(ad3[gi]), .rdata(d3[gi]));
    end
  endgenerate

  // fade pipeline, stages 1..3
  logic [F+3:0] inner2 [2], inner3 [2];
  logic [F-1:0] tt2 [2], c3 [2];
  logic [F:0] fade4 [2];
  logic signed [F+5:0] m6 [2];
  logic signed [F:0] ts [2];
  logic signed [2*F+6:0] pp [2];
  logic signed [2*F+6:0] pf [2];
  logic [2*F-1:0] sq [2], cu [2];
  logic [2*F+3:0] fp [2];

  generate
    for (gi = 0; gi < 2; gi++) begin : g_fade
      assign ts[gi] = $signed({1'b0, t1[gi]});
      assign m6[gi] = $signed({6'b0, t1[gi]}) * (F+6)'(6) - K15;
      assign pp[gi] = ts[gi] * m6[gi];
      assign pf[gi] = pp[gi] >>> F;
      assign sq[gi] = t1[gi] * t1[gi];
      assign cu[gi] = tt2[gi] * t2[gi];
      assign fp[gi] = c3[gi] * inner3[gi];
      always_ff @(posedge clk) begin
        if (en) begin
          inner2[gi] <= (F+4)'(pf[gi]) + K10;
          tt2[gi]    <= sq[gi][2*F-1:F];
          inner3[gi] <= inner2[gi];
          c3[gi]     <= cu[gi][2*F-1:F];
          fade4[gi]  <= fp[gi][2*F:F];
        end
      end
    end
  endgenerate

  // stage 3: gradients
  function automatic logic signed [RW-1:0] grad2(input logic [7:0] hs,
      input logic signed [RW-1:0] x, input logic signed [RW-1:0] y);
    logic [3:0] h;
    logic signed [RW-1:0] u, v;
    h = hs[3:0];
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : '0);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic signed [RW-1:0] grad1(input logic [7:0] hs,
      input logic signed [RW-1:0] x);
    logic signed [RW-1:0] g;
    g = RW'($signed({2'b0, hs[2:0]} + 5'd1) * x);
    return hs[3] ? -g : g;
  endfunction

  logic signed [RW-1:0] x0, y0, xm, ym;
  logic signed [RW-1:0] g4 [4];
  assign x0 = RW'($signed({1'b0, t3r[0]}));
  assign y0 = RW'($signed({1'b0, t3r[1]}));
  assign xm = x0 - KONE;
  assign ym = y0 - KONE;

  // stage 4/5: blends
  function automatic logic signed [RW-1:0] lerp(input logic [F:0] t,
      input logic signed [RW-1:0] a, input logic signed [RW-1:0] b);
    logic signed [RW:0] d;
    logic signed [RW+F+2:0] p;
    d = (RW+1)'(b) - (RW+1)'(a);
    p = $signed({1'b0, t}) * d;
    p = p >>> F;
    return a + RW'(p);
  endfunction

  logic signed [RW-1:0] l5 [2];
  logic signed [RW-1:0] res6;
  logic [F:0] v5;
  logic signed [XW-1:0] ext, shv;
  logic signed [gn2d_pkg::OUT_W-1:0] sat;

  assign ext = XW'(res6);
  assign shv = (ext <<< SH_L) >>> SH_R;
  always_comb begin
    if (shv > XW'(gn2d_pkg::OUT_MAX)) begin
      sat = gn2d_pkg::OUT_MAX;
    end else if (shv < XW'(gn2d_pkg::OUT_MIN)) begin
      sat = gn2d_pkg::OUT_MIN;
    end else begin
      sat = shv[gn2d_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1[0] <= coord_x[F-1:0];
      t1[1] <= coord_y[F-1:0];
      yi1   <= yi0;
      widx1 <= widx0;
      wval1 <= table_value;
      t2    <= t1;
      widx2 <= widx1;
      wval2 <= wval1;
      h1d[0] <= d2[0];
      h1d[1] <= d2[1];
      t3r   <= t2;
      if (ctl[3].op == gn2d_pkg::OP_1D) begin
        g4[0] <= grad1(h1d[0], x0);
        g4[1] <= grad1(h1d[1], xm);
        g4[2] <= '0;
        g4[3] <= '0;
      end else begin
        g4[0] <= grad2(d3[0], x0, y0);
        g4[1] <= grad2(d3[1], xm, y0);
        g4[2] <= grad2(d3[2], x0, ym);
        g4[3] <= grad2(d3[3], xm, ym);
      end
      l5[0] <= lerp(fade4[0], g4[0], g4[1]);
      l5[1] <= lerp(fade4[0], g4[2], g4[3]);
      v5    <= fade4[1];
      res6  <= (ctl[5].op == gn2d_pkg::OP_2D) ? lerp(v5, l5[0], l5[1]) : l5[0];
      noise_value <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 6; i++) begin
        ctl[i] <= '0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      ctl[1].vld <= in_fire;
      ctl[1].op  <= gn2d_pkg::op_t'(opcode);
      for (int i = 2; i <= 6; i++) begin
        ctl[i] <= ctl[i-1];
      end
      out_valid <= ctl[6].vld &&
                   (ctl[6].op == gn2d_pkg::OP_2D || ctl[6].op == gn2d_pkg::OP_1D);
    end
  end

  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_noise_out: assert property (@(posedge clk) disable iff (rst)
    en && ctl[6].vld && ctl[6].op == gn2d_pkg::OP_2D |=> out_valid)
    else $error("noise word lost at output");
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    en && ctl[6].vld && ctl[6].op == gn2d_pkg::OP_LOAD |=> !out_valid)
    else $error("load word produced output");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(ctl[3]) && $stable(g4[0]))
    else $error("pipeline moved during stall");

endmodule
